FILE: design/dpfrc_pkg.sv
// ----------------------------------------------------------------------------
// Shared definitions for the dedup packet FIFO
// Opcodes, sequencer states and fixed widths for the packet FIFO with
// duplicate rejection and destination/time-range counting.
// ----------------------------------------------------------------------------
`default_nettype none

package dpfrc_pkg;

  // Request opcode, carried on the slave-side tuser
  localparam int unsigned OP_W = 2;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_FWD   = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

  // Limit register
  localparam int unsigned CFG_W = 11;
  localparam logic [CFG_W-1:0] LIMIT_RESET = 11'd1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: design/dedup_packet_fifo_range_count.sv
// ----------------------------------------------------------------------------
// Dedup packet FIFO with range count
// Bounded circular FIFO of (source, destination, timestamp) entries. An add
// rejects exact duplicates and evicts the oldest entry when full, a forward
// pops the oldest entry, a count returns the number of matching entries for a
// destination within an inclusive time range.
// ----------------------------------------------------------------------------
// Sequence: a request is taken while idle, then N reads are issued (N =
//   occupancy for add and count, 1 for a forward on a non-empty FIFO, 0
//   otherwise), and the result is registered once the output register is free.
// Requests: a new one is taken only after the result is registered; the single
//   entry-memory read port feeds one stored entry per cycle to one shared compare.
// Reset: sequencer idle, FIFO empty, limit 1024; memory contents are not
//   cleared since only occupied slots are ever read.
`default_nettype none

module dedup_packet_fifo_range_count #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned TIME_BITS = 30
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,

  // Limit register write channel
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [dpfrc_pkg::CFG_W-1:0]            cfg_data_i,

  // Request stream
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // tdata, low to high: source, destination, timestamp, start_time,
  //   end_time, zero pad to bytes
  input  wire logic [((2*ID_BITS+3*TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: op
  input  wire logic [dpfrc_pkg::OP_W-1:0]             s_axis_tuser,

  // Result stream
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // tdata, low to high: accepted, packet_valid, out_source, out_destination,
  //   out_timestamp, match_count, zero pad to bytes
  output logic [((2+2*ID_BITS+TIME_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ENT_W  = 2*ID_BITS + TIME_BITS;
  localparam int unsigned LIM_W  = (dpfrc_pkg::CFG_W > CNT_W) ? dpfrc_pkg::CFG_W : CNT_W;
  localparam int unsigned OUT_W  = ((2 + 2*ID_BITS + TIME_BITS + CNT_W + 7) / 8) * 8;

  // Output field offsets
  localparam int unsigned O_ACC = 0;
  localparam int unsigned O_PV  = 1;
  localparam int unsigned O_SRC = 2;
  localparam int unsigned O_DST = O_SRC + ID_BITS;
  localparam int unsigned O_TS  = O_DST + ID_BITS;
  localparam int unsigned O_CNT = O_TS + TIME_BITS;

  // Input field offsets
  localparam int unsigned I_DST = ID_BITS;
  localparam int unsigned I_TS  = 2*ID_BITS;
  localparam int unsigned I_LO  = I_TS + TIME_BITS;
  localparam int unsigned I_HI  = I_LO + TIME_BITS;

  localparam logic [CNT_W:0]   DEPTH_S = (CNT_W+1)'(DEPTH);
  localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(DEPTH);

  // Fold a sum of a slot and an offset (below twice the depth) back into range
  function automatic logic [ADDR_W-1:0] wrap_slot(input logic [CNT_W:0] s);
    logic [CNT_W:0] t;
    t = s;
    if (s >= DEPTH_S) begin
      t = s - DEPTH_S;
    end
    return t[ADDR_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  dpfrc_pkg::state_e state_q, state_d;

  logic [dpfrc_pkg::CFG_W-1:0] lim_q;
  logic [ADDR_W-1:0]           head_q, head_d;
  logic [CNT_W-1:0]            occ_q, occ_d;

  // Latched request
  logic [dpfrc_pkg::OP_W-1:0]  op_q;
  logic [ID_BITS-1:0]          src_q, dst_q;
  logic [TIME_BITS-1:0]        ts_q, lo_q, hi_q;

  // Scan bookkeeping
  logic [CNT_W-1:0]            idx_q, idx_d;
  logic [CNT_W-1:0]            nrd_q, nrd_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic                        dup_q, dup_d;
  logic                        rd_vld_q;

  // Entry memory, entry = {timestamp, destination, source}
  logic [ENT_W-1:0]            mem [DEPTH];
  logic [ENT_W-1:0]            rd_data_q;
  logic                        rd_en;
  logic [ADDR_W-1:0]           rd_addr;
  logic                        wr_en;
  logic [ADDR_W-1:0]           wr_addr;

  // Result register
  logic                        m_valid_q;
  logic [OUT_W-1:0]            m_data_q, m_data_d;

  // Sequencer controls
  logic                        req_acc;
  logic                        finish;
  logic                        out_free;

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign req_acc       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dpfrc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = dpfrc_pkg::ST_READ;
        end
      end
      dpfrc_pkg::ST_READ: begin
        // Last read has returned once every read is issued
        if (idx_q == nrd_q) begin
          state_d = dpfrc_pkg::ST_DONE;
        end
      end
      dpfrc_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = dpfrc_pkg::ST_IDLE;
        end
      end
      default: state_d = dpfrc_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    finish        = 1'b0;
    unique case (state_q)
      dpfrc_pkg::ST_IDLE: s_axis_tready = 1'b1;
      dpfrc_pkg::ST_READ: rd_en         = (idx_q != nrd_q);
      dpfrc_pkg::ST_DONE: finish        = out_free;
      default: ;
    endcase
  end

  // Scan walks from the oldest slot forward
  assign rd_addr = wrap_slot({1'b0, CNT_W'(head_q)} + {1'b0, idx_q});

  // --------------------------------------------------------------------------
  // Shared compare unit: one stored entry per cycle
  // --------------------------------------------------------------------------
  logic [ID_BITS-1:0]   e_src, e_dst;
  logic [TIME_BITS-1:0] e_ts;
  logic                 hit_dup, hit_cnt;

  assign e_src   = rd_data_q[ID_BITS-1:0];
  assign e_dst   = rd_data_q[2*ID_BITS-1:ID_BITS];
  assign e_ts    = rd_data_q[ENT_W-1:2*ID_BITS];
  assign hit_dup = (e_src == src_q) && (e_dst == dst_q) && (e_ts == ts_q);
  assign hit_cnt = (e_dst == dst_q) && (e_ts >= lo_q) && (e_ts <= hi_q);

  always_comb begin
    idx_d = idx_q;
    nrd_d = nrd_q;
    cnt_d = cnt_q;
    dup_d = dup_q;
    if (req_acc) begin
      idx_d = '0;
      cnt_d = '0;
      dup_d = 1'b0;
      unique case (s_axis_tuser)
        dpfrc_pkg::OP_ADD,
        dpfrc_pkg::OP_COUNT: nrd_d = occ_q;
        dpfrc_pkg::OP_FWD:   nrd_d = (occ_q != '0) ? CNT_W'(1) : '0;
        default:             nrd_d = '0;
      endcase
    end else begin
      if (rd_en) begin
        idx_d = idx_q + CNT_W'(1);
      end
      if (rd_vld_q) begin
        if (hit_dup) begin
          dup_d = 1'b1;
        end
        if (hit_cnt) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Commit: update FIFO pointers, write the new entry, form the result
  // --------------------------------------------------------------------------
  logic [LIM_W-1:0] lim_ext, eff_lim;
  logic             full;

  assign lim_ext = LIM_W'(lim_q);

  always_comb begin
    if (lim_q == '0) begin
      eff_lim = LIM_W'(1);
    end else if (lim_ext > DEPTH_L) begin
      eff_lim = DEPTH_L;
    end else begin
      eff_lim = lim_ext;
    end
  end

  assign full = (LIM_W'(occ_q) >= eff_lim) && (occ_q != '0);

  // New entry goes at head + occupancy, whether or not the oldest is dropped
  assign wr_addr = wrap_slot({1'b0, CNT_W'(head_q)} + {1'b0, occ_q});

  always_comb begin
    head_d   = head_q;
    occ_d    = occ_q;
    wr_en    = 1'b0;
    m_data_d = '0;
    if (finish) begin
      unique case (op_q)
        dpfrc_pkg::OP_ADD: begin
          if (!dup_q) begin
            wr_en           = 1'b1;
            m_data_d[O_ACC] = 1'b1;
            if (full) begin
              // Drop the oldest, occupancy stays
              head_d = wrap_slot((CNT_W+1)'(head_q) + (CNT_W+1)'(1));
            end else begin
              occ_d = occ_q + CNT_W'(1);
            end
          end
        end
        dpfrc_pkg::OP_FWD: begin
          if (occ_q != '0) begin
            m_data_d[O_PV]                = 1'b1;
            m_data_d[O_SRC +: ID_BITS]    = e_src;
            m_data_d[O_DST +: ID_BITS]    = e_dst;
            m_data_d[O_TS  +: TIME_BITS]  = e_ts;
            head_d = wrap_slot((CNT_W+1)'(head_q) + (CNT_W+1)'(1));
            occ_d  = occ_q - CNT_W'(1);
          end
        end
        dpfrc_pkg::OP_COUNT: begin
          m_data_d[O_CNT +: CNT_W] = cnt_q;
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dpfrc_pkg::ST_IDLE;
      lim_q     <= dpfrc_pkg::LIMIT_RESET;
      head_q    <= '0;
      occ_q     <= '0;
      idx_q     <= '0;
      nrd_q     <= '0;
      cnt_q     <= '0;
      dup_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      occ_q    <= occ_d;
      idx_q    <= idx_d;
      nrd_q    <= nrd_d;
      cnt_q    <= cnt_d;
      dup_q    <= dup_d;
      rd_vld_q <= rd_en;
      if (cfg_valid_i) begin
        lim_q <= cfg_data_i;
      end
      if (finish) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Hold the request fields for the whole scan
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q  <= s_axis_tuser;
      src_q <= s_axis_tdata[ID_BITS-1:0];
      dst_q <= s_axis_tdata[I_DST +: ID_BITS];
      ts_q  <= s_axis_tdata[I_TS +: TIME_BITS];
      lo_q  <= s_axis_tdata[I_LO +: TIME_BITS];
      hi_q  <= s_axis_tdata[I_HI +: TIME_BITS];
    end
    if (finish) begin
      m_data_q <= m_data_d;
    end
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {ts_q, dst_q, src_q};
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/dpfrc_checker.sv
// ----------------------------------------------------------------------------
// Port checker for the dedup packet FIFO
// Watches the top-level ports for sequencing and result-format slips.
// ----------------------------------------------------------------------------
`default_nettype none

module dpfrc_checker #(
  parameter int unsigned DEPTH     = 1024,
  parameter int unsigned ID_BITS   = 16,
  parameter int unsigned TIME_BITS = 30
) (
  input wire logic                                   clk_i,
  input wire logic                                   rst_ni,
  input wire logic                                   s_axis_tvalid,
  input wire logic                                   s_axis_tready,
  input wire logic                                   m_axis_tvalid,
  input wire logic                                   m_axis_tready,
  input wire logic [((2+2*ID_BITS+TIME_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned O_SRC = 2;
  localparam int unsigned O_CNT = O_SRC + 2*ID_BITS + TIME_BITS;

  logic                              r_acc, r_pv;
  logic [2*ID_BITS+TIME_BITS-1:0]    r_pkt;
  logic [CNT_W-1:0]                  r_cnt;

  assign r_acc = m_axis_tdata[0];
  assign r_pv  = m_axis_tdata[1];
  assign r_pkt = m_axis_tdata[O_SRC +: 2*ID_BITS+TIME_BITS];
  assign r_cnt = m_axis_tdata[O_CNT +: CNT_W];

  // Not ready in the cycle after taking a request
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while previous one in progress");

  // A result answers only one kind of request
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot0({r_acc, r_pv, (r_cnt != '0)}))
    else $error("result mixes fields of several request kinds");

  // Packet fields are zero unless a packet was popped
  a_pkt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !r_pv) |-> (r_pkt == '0))
    else $error("packet fields nonzero without a popped packet");

  // Count never exceeds storage
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (r_cnt <= CNT_W'(DEPTH)))
    else $error("match count above depth");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind dedup_packet_fifo_range_count dpfrc_checker #(
  .DEPTH    (DEPTH),
  .ID_BITS  (ID_BITS),
  .TIME_BITS(TIME_BITS)
) u_dpfrc_checker (.*);

`default_nettype wire

FILE: verif/packet_fifo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet FIFO result checker
// Watches the limit write channel, the request stream and the result stream.
// Keeps its own copy of the stored packets and the limit, works out the
// result of every accepted request, and compares each result field by field
// with the oldest outstanding one.
// ----------------------------------------------------------------------------
module packet_fifo_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [dpfrc_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                        req_valid_i,
  input  logic                        req_ready_i,
  input  logic [127:0]                req_data_i,
  input  logic [dpfrc_pkg::OP_W-1:0]  req_op_i,
  input  logic                        rsp_valid_i,
  input  logic                        rsp_ready_i,
  input  logic [79:0]                 rsp_data_i,
  output int                          mismatch_o,
  output int                          pending_o
);

  localparam int unsigned DEPTH = 1024;

  typedef struct packed {
    logic [5:0]  pad;
    logic [29:0] end_time;
    logic [29:0] start_time;
    logic [29:0] stamp;
    logic [15:0] dst;
    logic [15:0] src;
  } request_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [10:0] match_count;
    logic [29:0] out_timestamp;
    logic [15:0] out_destination;
    logic [15:0] out_source;
    logic        packet_valid;
    logic        accepted;
  } result_t;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] dst;
    logic [29:0] stamp;
  } packet_t;

  packet_t                     held_packets[$];
  result_t                     pending_results[$];
  logic [dpfrc_pkg::CFG_W-1:0] limit_reg;
  int                          mismatch_count;

  function automatic int unsigned effective_limit();
    if (limit_reg == '0) return 1;
    if (limit_reg > DEPTH) return DEPTH;
    return limit_reg;
  endfunction

  // Apply one request to the held packets and return its result
  function automatic result_t predict_result(input logic [1:0] op, input request_t req);
    result_t     res;
    packet_t     pkt;
    logic        dup;
    int unsigned hits;
    res  = '0;
    dup  = 1'b0;
    hits = 0;
    pkt  = '{src: req.src, dst: req.dst, stamp: req.stamp};
    case (op)
      dpfrc_pkg::OP_ADD: begin
        foreach (held_packets[i])
          if (held_packets[i] == pkt) dup = 1'b1;
        if (!dup) begin
          // evict exactly one, even when the limit dropped below occupancy
          if (held_packets.size() >= effective_limit() && held_packets.size() > 0)
            void'(held_packets.pop_front());
          held_packets.insert(held_packets.size(), pkt);
          res.accepted = 1'b1;
        end
      end
      dpfrc_pkg::OP_FWD: begin
        if (held_packets.size() > 0) begin
          pkt                 = held_packets.pop_front();
          res.packet_valid    = 1'b1;
          res.out_source      = pkt.src;
          res.out_destination = pkt.dst;
          res.out_timestamp   = pkt.stamp;
        end
      end
      dpfrc_pkg::OP_COUNT: begin
        foreach (held_packets[i])
          if (held_packets[i].dst == req.dst && held_packets[i].stamp >= req.start_time &&
              held_packets[i].stamp <= req.end_time)
            hits++;
        res.match_count = hits[10:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      held_packets.delete();
      pending_results.delete();
      limit_reg      = dpfrc_pkg::LIMIT_RESET;
      mismatch_count = 0;
      mismatch_o    <= 0;
      pending_o     <= 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        got = rsp_data_i;
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: data %h", rsp_data_i);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("accepted", want.accepted, got.accepted);
          check_field("packet_valid", want.packet_valid, got.packet_valid);
          check_field("out_source", want.out_source, got.out_source);
          check_field("out_destination", want.out_destination, got.out_destination);
          check_field("out_timestamp", want.out_timestamp, got.out_timestamp);
          check_field("match_count", want.match_count, got.match_count);
        end
      end
      if (cfg_valid_i && cfg_ready_i) limit_reg = cfg_data_i;
      if (req_valid_i && req_ready_i)
        pending_results.insert(pending_results.size(), predict_result(req_op_i, req_data_i));
      mismatch_o <= mismatch_count;
      pending_o  <= pending_results.size();
    end
  end

endmodule

FILE: verif/dedup_packet_fifo_range_count_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dedup packet FIFO testbench
// Drives adds, forwards, counts and unused opcodes into the packet FIFO under
// a range of limit settings, with random idling on both streams. A separate
// checker predicts every result and compares it; this module only makes the
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module dedup_packet_fifo_range_count_tb;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned ID_BITS     = 16;
  localparam int unsigned TIME_BITS   = 30;
  localparam int unsigned REQ_W       = 128;
  localparam int unsigned RSP_W       = 80;
  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned PHASE_ITEMS = 55;
  // a full scan plus a long receiver stall stays far below this
  localparam int unsigned STALL_LIMIT = 20000;
  localparam logic [dpfrc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [15:0]     ID_MAX    = 16'hFFFF;
  localparam logic [29:0]     TS_MAX    = 30'h3FFF_FFFF;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [dpfrc_pkg::CFG_W-1:0]   cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // source, destination, timestamp, start_time, end_time, zero pad
  logic [REQ_W-1:0]              s_axis_tdata  = '0;
  // op
  logic [dpfrc_pkg::OP_W-1:0]    s_axis_tuser  = dpfrc_pkg::OP_ADD;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // accepted, packet_valid, out_source, out_destination, out_timestamp,
  // match_count, zero pad
  logic [RSP_W-1:0]              m_axis_tdata;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  bit pacing_on    = 1'b1;

  // Recent adds, replayed to provoke duplicate rejection
  logic [15:0] recent_src[8];
  logic [15:0] recent_dst[8];
  logic [29:0] recent_ts[8];
  int          recent_n  = 0;
  int          recent_wr = 0;
  logic [29:0] ts_base   = 30'd20;

  // Limit settings per random phase: extremes, zero, above depth, small
  int unsigned phase_limits[8] = '{4, 1, 16, 2047, 0, 64, 1024, 8};

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  dedup_packet_fifo_range_count #(
    .DEPTH     (DEPTH),
    .ID_BITS   (ID_BITS),
    .TIME_BITS (TIME_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  packet_fifo_checker result_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_op_i    (s_axis_tuser),
    .rsp_valid_i (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_data_i  (m_axis_tdata),
    .mismatch_o  (mismatches),
    .pending_o   (outstanding)
  );

  // Stall the result side in about a quarter of the cycles while pacing is on
  always @(posedge clk_i) begin
    m_axis_tready <= !pacing_on || ($urandom_range(99) >= 26);
  end

  // Watchdog: end the run after a long stretch with no handshake anywhere
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one request and hold it until it is taken; idle before it at random
  task automatic send_request(input logic [dpfrc_pkg::OP_W-1:0] op, input logic [15:0] src,
                              input logic [15:0] dst, input logic [29:0] stamp,
                              input logic [29:0] lo, input logic [29:0] hi);
    if (pacing_on)
      while ($urandom_range(99) < 26) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, hi, lo, stamp, dst, src};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off new requests until every outstanding result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [dpfrc_pkg::CFG_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed traffic: nondecreasing timestamps, few destinations,
  // replays of recent adds, count windows around the latest timestamp
  task automatic random_request();
    int unsigned pick;
    int unsigned span;
    int          slot;
    logic [dpfrc_pkg::OP_W-1:0] op;
    logic [15:0] src;
    logic [15:0] dst;
    logic [29:0] stamp;
    logic [29:0] lo;
    logic [29:0] hi;
    pick  = $urandom_range(99);
    src   = 16'($urandom);
    dst   = 16'($urandom);
    stamp = 30'($urandom);
    lo    = 30'($urandom);
    hi    = 30'($urandom);
    if (pick < 48) begin
      op = dpfrc_pkg::OP_ADD;
      if (recent_n > 0 && $urandom_range(99) < 20) begin
        slot  = int'($urandom_range(recent_n - 1));
        src   = recent_src[slot];
        dst   = recent_dst[slot];
        stamp = recent_ts[slot];
      end else begin
        if ($urandom_range(3) != 0) src = 16'($urandom_range(3));
        if ($urandom_range(3) != 0) dst = 16'($urandom_range(3));
        if ($urandom_range(9) != 0) begin
          ts_base = ts_base + 30'($urandom_range(2));
          stamp   = ts_base;
        end
        recent_src[recent_wr] = src;
        recent_dst[recent_wr] = dst;
        recent_ts[recent_wr]  = stamp;
        recent_wr = (recent_wr + 1) % 8;
        if (recent_n < 8) recent_n++;
      end
    end else if (pick < 68) begin
      op = dpfrc_pkg::OP_FWD;
    end else if (pick < 94) begin
      op = dpfrc_pkg::OP_COUNT;
      if ($urandom_range(3) != 0) dst = 16'($urandom_range(3));
      if ($urandom_range(6) != 0) begin
        span = (ts_base < 30'd8) ? 32'(ts_base) : 32'd8;
        lo   = ts_base - 30'($urandom_range(span));
        hi   = lo + 30'($urandom_range(10));
      end
    end else begin
      op = OP_UNUSED;
    end
    send_request(op, src, dst, stamp, lo, hi);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty FIFO: forward reports nothing, count is zero
    send_request(dpfrc_pkg::OP_FWD, 16'd0, 16'd0, 30'd0, 30'd0, 30'd0);
    send_request(dpfrc_pkg::OP_COUNT, 16'd0, 16'd0, 30'd0, 30'd0, TS_MAX);
    // Field extremes, then a duplicate of the oldest entry
    send_request(dpfrc_pkg::OP_ADD, 16'd0, 16'd0, 30'd0, 30'd0, 30'd0);
    send_request(dpfrc_pkg::OP_ADD, ID_MAX, ID_MAX, TS_MAX, TS_MAX, TS_MAX);
    send_request(dpfrc_pkg::OP_ADD, 16'd0, 16'd0, 30'd0, TS_MAX, TS_MAX);
    send_request(dpfrc_pkg::OP_COUNT, ID_MAX, 16'd0, 30'(ID_MAX), 30'd0, 30'd0);
    send_request(dpfrc_pkg::OP_COUNT, 16'd0, ID_MAX, 30'd0, 30'd0, TS_MAX);
    // Reversed range counts nothing
    send_request(dpfrc_pkg::OP_COUNT, 16'd0, ID_MAX, 30'd0, TS_MAX, 30'd0);
    // Unused opcode leaves the FIFO alone
    send_request(OP_UNUSED, ID_MAX, ID_MAX, TS_MAX, TS_MAX, TS_MAX);
    send_request(dpfrc_pkg::OP_FWD, 16'd0, 16'd0, 30'd0, 30'd0, 30'd0);
    send_request(dpfrc_pkg::OP_FWD, ID_MAX, ID_MAX, TS_MAX, TS_MAX, TS_MAX);
    send_request(dpfrc_pkg::OP_FWD, 16'd0, 16'd0, 30'd0, 30'd0, 30'd0);

    // Limit of two: duplicate of the oldest while full evicts nothing
    write_limit(11'd2);
    send_request(dpfrc_pkg::OP_ADD, 16'd1, 16'd1, 30'd10, 30'd0, 30'd0);
    send_request(dpfrc_pkg::OP_ADD, 16'd2, 16'd1, 30'd10, 30'd0, 30'd0);
    send_request(dpfrc_pkg::OP_ADD, 16'd1, 16'd1, 30'd10, 30'd0, 30'd0);
    send_request(dpfrc_pkg::OP_ADD, 16'd3, 16'd1, 30'd11, 30'd0, 30'd0);
    send_request(dpfrc_pkg::OP_COUNT, 16'd0, 16'd1, 30'd0, 30'd10, 30'd11);
    send_request(dpfrc_pkg::OP_FWD, 16'd0, 16'd0, 30'd0, 30'd0, 30'd0);

    // Zero limit behaves as one
    write_limit(11'd0);
    send_request(dpfrc_pkg::OP_ADD, 16'd4, 16'd2, 30'd12, 30'd0, 30'd0);
    send_request(dpfrc_pkg::OP_COUNT, 16'd0, 16'd2, 30'd0, 30'd0, TS_MAX);

    // Limit above depth, then lowered below occupancy: one eviction per add
    write_limit(11'd2047);
    send_request(dpfrc_pkg::OP_ADD, 16'd5, 16'd2, 30'd13, 30'd0, 30'd0);
    send_request(dpfrc_pkg::OP_ADD, 16'd6, 16'd2, 30'd14, 30'd0, 30'd0);
    send_request(dpfrc_pkg::OP_ADD, 16'd7, 16'd2, 30'd15, 30'd0, 30'd0);
    write_limit(11'd2);
    send_request(dpfrc_pkg::OP_ADD, 16'd8, 16'd2, 30'd16, 30'd0, 30'd0);
    send_request(dpfrc_pkg::OP_COUNT, 16'd0, 16'd2, 30'd0, 30'd12, 30'd16);

    // Random phases; each limit write first waits for all results (pressure),
    // and one phase runs with no idling on either side
    for (int p = 0; p < 8; p++) begin
      write_limit(phase_limits[p][dpfrc_pkg::CFG_W-1:0]);
      pacing_on = (p != 3);
      repeat (PHASE_ITEMS) random_request();
    end
    pacing_on = 1'b1;

    drain();
    repeat (DEPTH + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
